>>> design/bsc_pkg.sv
// Shared types and constants for the barometer sample compensation block.
`default_nettype none
package bsc_pkg;

  localparam int unsigned DivWidth = 64;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic signed [31:0] pressure_pascal;
    logic signed [31:0] altitude_centimetre;
    logic               sample_healthy;
  } bsc_out_t;

  typedef enum logic [7:0] {
    CFG_TEMP_CALIB = 8'd0,
    CFG_PRESS_LOW  = 8'd1,
    CFG_PRESS_HIGH = 8'd2,
    CFG_PRESS_NINE = 8'd3
  } bsc_cfg_idx_t;

  // Sideband that travels with an item through the divider.
  typedef struct packed {
    logic [15:0] temp;
    logic        zero;
    logic        neg;
  } bsc_side_t;

  localparam logic [33:0] T_OFFSET    = 34'd128000;
  localparam logic [31:0] T_ROUND     = 32'd128;
  localparam logic [20:0] P_FULL      = 21'd1048576;
  localparam logic [63:0] P_SCALE     = 64'd3125;
  localparam logic [63:0] P_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic [31:0] SEA_LEVEL   = 32'd101325;
  localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

endpackage
`default_nettype wire

>>> design/barometer_sample_compensation.sv
// Top level of the barometer sample compensation pipeline.
// Stages: front s1..s11, quotient pipeline, back p1..p9 (p9 is the output register).
// Throughput: one item per cycle unless stalled; 64 quotient stages set the depth.
// Stall: the whole pipeline holds while the output item waits; nothing drops.
// Reset: rst (synchronous) clears all valid bits and the calibration registers.
`default_nettype none
module barometer_sample_compensation (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsc_pkg::bsc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bsc_pkg::bsc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import bsc_pkg::*;

  // Calibration registers: user writes them only while pipeline is empty; not enforced.
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_nine;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_nine <= '0;
    end else if (cfg_valid) begin
      unique case (bsc_cfg_idx_t'(cfg_index))
        CFG_TEMP_CALIB: temp_calib       <= cfg_data[47:0];
        CFG_PRESS_LOW:  press_calib_low  <= cfg_data;
        CFG_PRESS_HIGH: press_calib_high <= cfg_data;
        CFG_PRESS_NINE: press_calib_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient slices.
  logic [15:0]        t1;
  logic [31:0]        t2s;
  logic [31:0]        t3s;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1  = temp_calib[15:0];
  assign t2s = {{16{temp_calib[31]}}, temp_calib[31:16]};
  assign t3s = {{16{temp_calib[47]}}, temp_calib[47:32]};
  assign p1  = press_calib_low[15:0];
  assign p2  = press_calib_low[31:16];
  assign p3  = press_calib_low[47:32];
  assign p4  = press_calib_low[63:48];
  assign p5  = press_calib_high[15:0];
  assign p6  = press_calib_high[31:16];
  assign p7  = press_calib_high[47:32];
  assign p8  = press_calib_high[63:48];
  assign p9  = press_calib_nine;

  // Global advance: every stage moves together unless the output item is held.
  logic        en;
  logic [10:0] sv;   // valid bits, front stages s1..s11
  logic [8:0]  pv;   // valid bits, back stages p1..p9
  logic        div_valid;

  assign en        = ~pv[8] | out_ready;
  assign in_ready  = en;
  assign out_valid = pv[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      pv <= '0;
    end else if (en) begin
      sv <= {sv[9:0], in_valid};
      pv <= {pv[7:0], div_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages: temperature path (32-bit wrap), then the pressure divisor
  // and dividend (64-bit wrap). Multiplications are cut into 32-bit partials.
  // ---------------------------------------------------------------------------
  logic [31:0] s1_d1, s1_d2;
  logic [19:0] s1_adc, s2_adc, s3_adc, s4_adc, s5_adc, s6_adc, s7_adc, s8_adc;
  logic [31:0] s2_m1, s2_m2;
  logic [31:0] s3_a1, s3_m3;
  logic [31:0] s4_fine;
  logic [15:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic [33:0] s5_x;
  logic [63:0] s6_xx;
  logic signed [49:0] s6_xp5, s6_xp2, s7_xp5, s7_xp2;
  logic signed [48:0] s7_y6lo, s7_x3lo;
  logic [31:0]        s7_y6hi, s7_x3hi;
  logic [63:0] s8_y, s8_x2;
  logic [47:0] s9_plo;
  logic [31:0] s9_phi;
  logic [63:0] s9_diff;
  logic [63:0] s10_num, s10_den;
  logic [63:0] s11_num, s11_den;
  bsc_side_t   s11_side;

  logic [31:0]        fine5;
  logic signed [67:0] xx_full;
  logic signed [49:0] xp5_full, xp2_full;
  logic signed [48:0] y6lo_c, x3lo_c;
  logic [63:0]        prod6, prod3, xp5_64, xp2_64, p4_64;
  logic [63:0]        bias_x;
  logic [47:0]        plo_c;
  logic [20:0]        pneg;
  logic [63:0]        prod1;

  assign fine5    = (s4_fine << 2) + s4_fine + T_ROUND;
  assign xx_full  = $signed(s5_x) * $signed(s5_x);
  assign xp5_full = $signed(s5_x) * p5;
  assign xp2_full = $signed(s5_x) * p2;
  assign y6lo_c   = $signed({1'b0, s6_xx[31:0]}) * p6;
  assign x3lo_c   = $signed({1'b0, s6_xx[31:0]}) * p3;
  assign prod6    = {{15{s7_y6lo[48]}}, s7_y6lo} + {s7_y6hi, 32'b0};
  assign prod3    = {{15{s7_x3lo[48]}}, s7_x3lo} + {s7_x3hi, 32'b0};
  assign xp5_64   = {{14{s7_xp5[49]}}, s7_xp5};
  assign xp2_64   = {{14{s7_xp2[49]}}, s7_xp2};
  assign p4_64    = {{48{p4[15]}}, p4};
  assign bias_x   = P_BIAS + s8_x2;
  assign plo_c    = bias_x[31:0] * p1;
  assign pneg     = P_FULL - {1'b0, s8_adc};
  assign prod1    = {16'b0, s9_plo} + {s9_phi, 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      // s1: offsets of the raw temperature
      s1_d1  <= {15'b0, in_data.raw_temperature[19:3]} - {15'b0, t1, 1'b0};
      s1_d2  <= {16'b0, in_data.raw_temperature[19:4]} - {16'b0, t1};
      s1_adc <= in_data.raw_pressure;
      // s2: first products
      s2_m1  <= s1_d1 * t2s;
      s2_m2  <= s1_d2 * s1_d2;
      s2_adc <= s1_adc;
      // s3
      s3_a1  <= 32'($signed(s2_m1) >>> 11);
      s3_m3  <= 32'($signed(s2_m2) >>> 12) * t3s;
      s3_adc <= s2_adc;
      // s4: fine temperature
      s4_fine <= s3_a1 + 32'($signed(s3_m3) >>> 14);
      s4_adc  <= s3_adc;
      // s5: centidegrees and pressure offset (fits in 34 bits)
      s5_temp <= fine5[23:8];
      s5_x    <= {{2{s4_fine[31]}}, s4_fine} - T_OFFSET;
      s5_adc  <= s4_adc;
      // s6: squares and linear terms
      s6_xx   <= xx_full[63:0];
      s6_xp5  <= xp5_full;
      s6_xp2  <= xp2_full;
      s6_temp <= s5_temp;
      s6_adc  <= s5_adc;
      // s7: partials of x*x times P6 and P3
      s7_y6lo <= y6lo_c;
      s7_y6hi <= s6_xx[63:32] * {{16{p6[15]}}, p6};
      s7_x3lo <= x3lo_c;
      s7_x3hi <= s6_xx[63:32] * {{16{p3[15]}}, p3};
      s7_xp5  <= s6_xp5;
      s7_xp2  <= s6_xp2;
      s7_temp <= s6_temp;
      s7_adc  <= s6_adc;
      // s8: sum up the dividend offset and the divisor polynomial
      s8_y    <= prod6 + (xp5_64 << 17) + (p4_64 << 35);
      s8_x2   <= 64'($signed(prod3) >>> 8) + (xp2_64 << 12);
      s8_temp <= s7_temp;
      s8_adc  <= s7_adc;
      // s9: partials of the divisor scaling by P1; raw dividend
      s9_plo  <= plo_c;
      s9_phi  <= bias_x[63:32] * {16'b0, p1};
      s9_diff <= {12'b0, pneg, 31'b0} - s8_y;
      s9_temp <= s8_temp;
      // s10
      s10_den  <= {{33{prod1[63]}}, prod1[63:33]};
      s10_num  <= s9_diff * P_SCALE;
      s10_temp <= s9_temp;
      // s11: magnitudes and quotient sign
      s11_num       <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      s11_den       <= s10_den[63] ? (64'd0 - s10_den) : s10_den;
      s11_side.temp <= s10_temp;
      s11_side.zero <= (s10_den == 64'd0);
      s11_side.neg  <= s10_num[63] ^ s10_den[63];
    end
  end

  // ---------------------------------------------------------------------------
  // Quotient pipeline
  // ---------------------------------------------------------------------------
  logic [63:0] div_quo;
  bsc_side_t   div_side;

  bsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sv[10]),
    .num      (s11_num),
    .den      (s11_den),
    .side_in  (s11_side),
    .out_valid(div_valid),
    .quo      (div_quo),
    .side_out (div_side)
  );

  // ---------------------------------------------------------------------------
  // Back stages: nonlinear correction, pressure, altitude.
  // ---------------------------------------------------------------------------
  logic [63:0] p1_q, p2_q, p3_q, p4_q, p5_q;
  bsc_side_t   p1_side, p2_side, p3_side, p4_side, p5_side, p6_side, p7_side, p8_side;
  logic signed [48:0] p2_lo9, p2_lo8;
  logic [31:0]        p2_hi9, p2_hi8;
  logic [63:0] p3_t, p3_e2, p4_e2, p5_e2;
  logic [63:0] p4_ll;
  logic [31:0] p4_lh, p4_hl;
  logic [63:0] p5_e1;
  logic [31:0] p6_pres, p7_pres, p8_pres;
  logic [31:0] p7_mag;
  logic        p7_neg, p8_neg;
  logic [30:0] p8_third;

  logic [63:0]        ps2, ps3;
  logic signed [48:0] lo9_c, lo8_c;
  logic [63:0]        sum9, sum8;
  logic [63:0]        e1_sum, comp, comp_sh;
  logic [31:0]        alt_a, alt_25;
  logic [63:0]        third_full;

  assign ps2        = 64'($signed(p1_q) >>> 13);
  assign ps3        = 64'($signed(p3_q) >>> 13);
  assign lo9_c      = $signed({1'b0, ps2[31:0]}) * p9;
  assign lo8_c      = $signed({1'b0, p1_q[31:0]}) * p8;
  assign sum9       = {{15{p2_lo9[48]}}, p2_lo9} + {p2_hi9, 32'b0};
  assign sum8       = {{15{p2_lo8[48]}}, p2_lo8} + {p2_hi8, 32'b0};
  assign e1_sum     = p4_ll + {p4_lh + p4_hl, 32'b0};
  assign comp       = p5_q + p5_e1 + p5_e2;
  assign comp_sh    = 64'($signed(comp) >>> 8) + ({{48{p7[15]}}, p7} << 4);
  assign alt_a      = SEA_LEVEL - p6_pres;
  assign alt_25     = (alt_a << 4) + (alt_a << 3) + alt_a;
  assign third_full = p7_mag * THIRD_RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      // p1: restore the quotient sign (most negative over -1 wraps by itself)
      p1_q    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
      p1_side <= div_side;
      // p2: partials of P9*(q>>13) and P8*q
      p2_lo9  <= lo9_c;
      p2_hi9  <= ps2[63:32] * {{16{p9[15]}}, p9};
      p2_lo8  <= lo8_c;
      p2_hi8  <= p1_q[63:32] * {{16{p8[15]}}, p8};
      p2_q    <= p1_q;
      p2_side <= p1_side;
      // p3
      p3_t    <= sum9;
      p3_e2   <= 64'($signed(sum8) >>> 19);
      p3_q    <= p2_q;
      p3_side <= p2_side;
      // p4: partials of (P9*ps)*ps
      p4_ll   <= p3_t[31:0] * ps3[31:0];
      p4_lh   <= p3_t[31:0] * ps3[63:32];
      p4_hl   <= p3_t[63:32] * ps3[31:0];
      p4_e2   <= p3_e2;
      p4_q    <= p3_q;
      p4_side <= p3_side;
      // p5
      p5_e1   <= 64'($signed(e1_sum) >>> 25);
      p5_e2   <= p4_e2;
      p5_q    <= p4_q;
      p5_side <= p4_side;
      // p6: pressure; zero divisor forces zero
      p6_pres <= p5_side.zero ? 32'd0 : comp_sh[39:8];
      p6_side <= p5_side;
      // p7: altitude magnitude
      p7_neg  <= alt_25[31];
      p7_mag  <= alt_25[31] ? (32'd0 - alt_25) : alt_25;
      p7_pres <= p6_pres;
      p7_side <= p6_side;
      // p8: divide by three through the reciprocal
      p8_third <= third_full[63:33];
      p8_neg   <= p7_neg;
      p8_pres  <= p7_pres;
      p8_side  <= p7_side;
      // p9: output register
      out_data.temperature_centi   <= p8_side.temp;
      out_data.pressure_pascal     <= p8_pres;
      out_data.altitude_centimetre <= p8_neg ? (32'd0 - {1'b0, p8_third})
                                             : {1'b0, p8_third};
      out_data.sample_healthy      <= (p8_pres != 32'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> sv[0])
    else $error("accepted item did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(sv) && $stable(pv)))
    else $error("pipeline valid bits moved during a stall");

  a_div_handover: assert property (@(posedge clk) disable iff (rst)
    (en && div_valid) |=> pv[0])
    else $error("item lost leaving the quotient pipeline");

  a_zero_pressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.pressure_pascal == 32'sd0) |->
      (out_data.altitude_centimetre == 32'sd844375 && !out_data.sample_healthy))
    else $error("zero pressure gave wrong altitude or health");

endmodule
`default_nettype wire

>>> design/bsc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module bsc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bsc_pkg::DivWidth-1:0]  num,
  input  logic [bsc_pkg::DivWidth-1:0]  den,
  input  bsc_pkg::bsc_side_t            side_in,
  output logic                          out_valid,
  output logic [bsc_pkg::DivWidth-1:0]  quo,
  output bsc_pkg::bsc_side_t            side_out
);
  import bsc_pkg::*;

  localparam int unsigned N = DivWidth;

  logic         vld    [N];
  logic [N-1:0] rem    [N];
  logic [N-1:0] num_sh [N];
  logic [N-1:0] den_q  [N];
  bsc_side_t    side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic         v_in;
    logic [N-1:0] r_in;
    logic [N-1:0] n_in;
    logic [N-1:0] d_in;
    bsc_side_t    s_in;
    logic [N:0]   trial;
    logic [N:0]   diff;
    logic         take;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign n_in = num_sh[i-1];
      assign d_in = den_q[i-1];
      assign s_in = side_q[i-1];
    end

    // Shift in the next numerator bit and try the subtraction.
    assign trial = {r_in, n_in[N-1]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = ~diff[N];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]    <= take ? diff[N-1:0] : trial[N-1:0];
        num_sh[i] <= {n_in[N-2:0], take};
        den_q[i]  <= d_in;
        side_q[i] <= s_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = num_sh[N-1];
  assign side_out  = side_q[N-1];

endmodule
`default_nettype wire
